[hw/rtl/slab_ms_pkg.sv]
// ============================================================================
// slab_ms_pkg
// Shared widths, request codes and mark codes for the mark/sweep slab
// allocator.
// ============================================================================
package slab_ms_pkg;

    // Arena geometry
    localparam int SLOTS  = 32768;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = 16;
    localparam int MODE_W = 2;
    localparam int MARK_W = 2;

    // Request kinds
    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MARK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SWEEP = 2'd2;

    // Mark colors
    localparam logic [MARK_W-1:0] MARK_WHITE = 2'd0;
    localparam logic [MARK_W-1:0] MARK_GREY  = 2'd1;
    localparam logic [MARK_W-1:0] MARK_BLACK = 2'd2;
    localparam logic [MARK_W-1:0] MARK_SPARE = 2'd3;

    // Fill threshold: population below ROOM_NUM / ROOM_DEN of the slots
    localparam int ROOM_NUM  = 49;
    localparam int ROOM_DEN  = 50;
    localparam int PROD_W    = CNT_W + 6;

endpackage

[hw/rtl/slab_ms_if.sv]
// ============================================================================
// slab_ms_if
// Valid/ready channels of the slab allocator: request and response.
// ============================================================================
interface slab_ms_req_if;
    logic                              valid;
    logic                              ready;
    logic [slab_ms_pkg::MODE_W-1:0]    mode;
    logic [slab_ms_pkg::SLOT_W-1:0]    slot;
    logic [slab_ms_pkg::MARK_W-1:0]    mark_value;

    modport source (output valid, output mode, output slot, output mark_value,
                    input ready);
    modport sink   (input valid, input mode, input slot, input mark_value,
                    output ready);
endinterface

interface slab_ms_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [slab_ms_pkg::SLOT_W-1:0]    slot_out;
    logic                              ok;
    logic [slab_ms_pkg::MARK_W-1:0]    old_mark;
    logic [slab_ms_pkg::CNT_W-1:0]     live_count;
    logic                              arena_empty;
    logic                              has_room;

    modport source (output valid, output slot_out, output ok, output old_mark,
                    output live_count, output arena_empty, output has_room,
                    input ready);
    modport sink   (input valid, input slot_out, input ok, input old_mark,
                    input live_count, input arena_empty, input has_room,
                    output ready);
endinterface

[hw/rtl/slab_ms_ram.sv]
// ============================================================================
// slab_ms_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is issued.
// ============================================================================
module slab_ms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/slab_ms_top.sv]
// ============================================================================
// slab_allocator_mark_sweep_top
// Slot allocator for one arena: LIFO free list with bump fallback, a 2-bit
// mark per slot, and a sweep that rebuilds the free list from white slots.
// ============================================================================
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+-------------------------------------
//  req     | in  | valid/ready       | mode, slot, mark_value
//  rsp     | out | valid/ready       | slot_out, ok, old_mark, live_count,
//          |     |                   | arena_empty, has_room
//  cfg     | in  | cfg_wr_en         | cfg_wr_data (slot_count)
//
//  Alloc, mark and no-op items are accepted in IDLE and finish in EXEC after
//  one RAM read. A sweep walks min(bump, usable slots) slots in SWEEP and
//  answers from DONE; the mark RAM read port walks one slot per cycle.
//  After reset the mark RAM is cleared one slot per cycle, all 32768 slots,
//  with req.ready low. Configuration writes are taken at any time.
//  Results go to an output register; a stalled rsp holds only the finishing
//  step, and a new item is taken while a result still waits.
// ============================================================================
module slab_allocator_mark_sweep_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [slab_ms_pkg::CNT_W-1:0]   cfg_wr_data,
    slab_ms_req_if.sink                     req,
    slab_ms_rsp_if.source                   rsp
);

    localparam int SLOT_W = slab_ms_pkg::SLOT_W;
    localparam int CNT_W  = slab_ms_pkg::CNT_W;
    localparam int MARK_W = slab_ms_pkg::MARK_W;
    localparam int MODE_W = slab_ms_pkg::MODE_W;
    localparam int PROD_W = slab_ms_pkg::PROD_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_SWEEP = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [CNT_W-1:0]  SLOTS_C   = CNT_W'(slab_ms_pkg::SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(slab_ms_pkg::SLOTS - 1);
    localparam logic [CNT_W-1:0]  CNT_MAX   = '1;

    // State
    logic [2:0]        state_reg,      state_next;
    logic [SLOT_W-1:0] clr_idx_reg,    clr_idx_next;
    logic [CNT_W-1:0]  slot_count_reg, slot_count_next;
    logic [MODE_W-1:0] op_mode_reg,    op_mode_next;
    logic [SLOT_W-1:0] op_slot_reg,    op_slot_next;
    logic [MARK_W-1:0] op_mark_reg,    op_mark_next;
    logic [SLOT_W-1:0] free_head_reg,  free_head_next;
    logic              free_empty_reg, free_empty_next;
    logic [CNT_W-1:0]  bump_reg,       bump_next;
    logic [CNT_W-1:0]  count_reg,      count_next;
    logic [CNT_W-1:0]  sw_idx_reg,     sw_idx_next;
    logic [CNT_W-1:0]  sw_limit_reg,   sw_limit_next;
    logic              pv_vld_reg,     pv_vld_next;
    logic [SLOT_W-1:0] pv_idx_reg,     pv_idx_next;

    // Output register
    logic              rsp_valid_reg,  rsp_valid_next;
    logic [SLOT_W-1:0] rsp_slot_reg,   rsp_slot_next;
    logic              rsp_ok_reg,     rsp_ok_next;
    logic [MARK_W-1:0] rsp_old_reg,    rsp_old_next;
    logic [CNT_W-1:0]  rsp_live_reg,   rsp_live_next;
    logic              rsp_empty_reg,  rsp_empty_next;
    logic              rsp_room_reg,   rsp_room_next;

    // RAM ports
    logic              mark_we, mark_re;
    logic [SLOT_W-1:0] mark_waddr, mark_raddr;
    logic [MARK_W-1:0] mark_wdata, mark_rdata;
    logic              link_we, link_re;
    logic [SLOT_W-1:0] link_waddr, link_raddr;
    logic [SLOT_W-1:0] link_wdata, link_rdata;

    logic [CNT_W-1:0]  usable;
    logic [CNT_W-1:0]  count_inc;
    logic              out_free;
    logic [PROD_W-1:0] live_x50;
    logic [PROD_W-1:0] usable_x49;

    slab_ms_ram #(.WIDTH(MARK_W), .DEPTH(slab_ms_pkg::SLOTS)) u_mark_ram (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .re    (mark_re),
        .raddr (mark_raddr),
        .rdata (mark_rdata)
    );

    slab_ms_ram #(.WIDTH(SLOT_W), .DEPTH(slab_ms_pkg::SLOTS)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    // Clamp the configured slot count to the arena size
    assign usable    = (slot_count_reg < SLOTS_C) ? slot_count_reg : SLOTS_C;
    assign count_inc = (count_reg == CNT_MAX) ? count_reg : count_reg + CNT_W'(1);
    assign out_free  = !rsp_valid_reg || rsp.ready;

    // Fill threshold products
    assign live_x50   = PROD_W'(count_reg) * PROD_W'(slab_ms_pkg::ROOM_DEN);
    assign usable_x49 = PROD_W'(usable) * PROD_W'(slab_ms_pkg::ROOM_NUM);

    // Handshake outputs
    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.slot_out    = rsp_slot_reg;
    assign rsp.ok          = rsp_ok_reg;
    assign rsp.old_mark    = rsp_old_reg;
    assign rsp.live_count  = rsp_live_reg;
    assign rsp.arena_empty = rsp_empty_reg;
    assign rsp.has_room    = rsp_room_reg;

    // Sequencer: clear pass, request decode, finish step and sweep walk
    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        slot_count_next = cfg_wr_en ? cfg_wr_data : slot_count_reg;
        op_mode_next    = op_mode_reg;
        op_slot_next    = op_slot_reg;
        op_mark_next    = op_mark_reg;
        free_head_next  = free_head_reg;
        free_empty_next = free_empty_reg;
        bump_next       = bump_reg;
        count_next      = count_reg;
        sw_idx_next     = sw_idx_reg;
        sw_limit_next   = sw_limit_reg;
        pv_vld_next     = pv_vld_reg;
        pv_idx_next     = pv_idx_reg;

        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_slot_next   = rsp_slot_reg;
        rsp_ok_next     = rsp_ok_reg;
        rsp_old_next    = rsp_old_reg;
        rsp_live_next   = rsp_live_reg;
        rsp_empty_next  = rsp_empty_reg;
        rsp_room_next   = rsp_room_reg;

        mark_we    = 1'b0;
        mark_waddr = '0;
        mark_wdata = slab_ms_pkg::MARK_WHITE;
        mark_re    = 1'b0;
        mark_raddr = '0;
        link_we    = 1'b0;
        link_waddr = '0;
        link_wdata = '0;
        link_re    = 1'b0;
        link_raddr = free_head_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                // Whiten one slot per cycle
                mark_we      = 1'b1;
                mark_waddr   = clr_idx_reg;
                clr_idx_next = clr_idx_reg + SLOT_W'(1);
                if (clr_idx_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_mode_next = req.mode;
                    op_slot_next = req.slot;
                    op_mark_next = req.mark_value;
                    state_next   = ST_EXEC;
                    case (req.mode)
                        slab_ms_pkg::MODE_ALLOC:
                        begin
                            link_re = 1'b1;
                        end
                        slab_ms_pkg::MODE_MARK:
                        begin
                            mark_re    = 1'b1;
                            mark_raddr = req.slot;
                        end
                        slab_ms_pkg::MODE_SWEEP:
                        begin
                            // Drop the free list and recount from zero
                            free_empty_next = 1'b1;
                            free_head_next  = '0;
                            count_next      = '0;
                            sw_idx_next     = '0;
                            sw_limit_next   = (bump_reg < usable) ? bump_reg : usable;
                            pv_vld_next     = 1'b0;
                            state_next      = ST_SWEEP;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_EXEC:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_slot_next  = '0;
                    rsp_ok_next    = 1'b0;
                    rsp_old_next   = slab_ms_pkg::MARK_WHITE;
                    rsp_empty_next = 1'b0;
                    rsp_room_next  = 1'b0;
                    case (op_mode_reg)
                        slab_ms_pkg::MODE_ALLOC:
                        begin
                            if (!free_empty_reg)
                            begin
                                // Pop; a self-link ends the list
                                rsp_slot_next = free_head_reg;
                                rsp_ok_next   = 1'b1;
                                count_next    = count_inc;
                                if (link_rdata == free_head_reg)
                                begin
                                    free_empty_next = 1'b1;
                                end
                                else
                                begin
                                    free_head_next = link_rdata;
                                end
                            end
                            else if (bump_reg < usable)
                            begin
                                rsp_slot_next = bump_reg[SLOT_W-1:0];
                                rsp_ok_next   = 1'b1;
                                bump_next     = bump_reg + CNT_W'(1);
                                count_next    = count_inc;
                            end
                        end
                        slab_ms_pkg::MODE_MARK:
                        begin
                            if ({1'b0, op_slot_reg} < usable)
                            begin
                                rsp_ok_next  = 1'b1;
                                rsp_old_next = mark_rdata;
                                mark_we      = 1'b1;
                                mark_waddr   = op_slot_reg;
                                mark_wdata   = (op_mark_reg == slab_ms_pkg::MARK_SPARE) ?
                                               slab_ms_pkg::MARK_BLACK : op_mark_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    rsp_live_next = count_next;
                    state_next    = ST_IDLE;
                end
            end

            ST_SWEEP:
            begin
                // Issue the next mark read
                if (sw_idx_reg < sw_limit_reg)
                begin
                    mark_re     = 1'b1;
                    mark_raddr  = sw_idx_reg[SLOT_W-1:0];
                    sw_idx_next = sw_idx_reg + CNT_W'(1);
                    pv_vld_next = 1'b1;
                    pv_idx_next = sw_idx_reg[SLOT_W-1:0];
                end
                else
                begin
                    pv_vld_next = 1'b0;
                    if (!pv_vld_reg)
                    begin
                        state_next = ST_DONE;
                    end
                end

                // Retire the slot read last cycle
                if (pv_vld_reg)
                begin
                    if (mark_rdata == slab_ms_pkg::MARK_WHITE)
                    begin
                        link_we         = 1'b1;
                        link_waddr      = pv_idx_reg;
                        link_wdata      = free_empty_reg ? pv_idx_reg : free_head_reg;
                        free_head_next  = pv_idx_reg;
                        free_empty_next = 1'b0;
                    end
                    else
                    begin
                        mark_we    = 1'b1;
                        mark_waddr = pv_idx_reg;
                        count_next = count_inc;
                    end
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_slot_next  = '0;
                    rsp_ok_next    = 1'b0;
                    rsp_old_next   = slab_ms_pkg::MARK_WHITE;
                    rsp_live_next  = count_reg;
                    rsp_empty_next = (count_reg == '0);
                    rsp_room_next  = (live_x50 < usable_x49);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_idx_reg    <= '0;
            slot_count_reg <= SLOTS_C;
            free_head_reg  <= '0;
            free_empty_reg <= 1'b1;
            bump_reg       <= '0;
            count_reg      <= '0;
            sw_idx_reg     <= '0;
            sw_limit_reg   <= '0;
            pv_vld_reg     <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            slot_count_reg <= slot_count_next;
            free_head_reg  <= free_head_next;
            free_empty_reg <= free_empty_next;
            bump_reg       <= bump_next;
            count_reg      <= count_next;
            sw_idx_reg     <= sw_idx_next;
            sw_limit_reg   <= sw_limit_next;
            pv_vld_reg     <= pv_vld_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_mode_reg   <= op_mode_next;
        op_slot_reg   <= op_slot_next;
        op_mark_reg   <= op_mark_next;
        pv_idx_reg    <= pv_idx_next;
        rsp_slot_reg  <= rsp_slot_next;
        rsp_ok_reg    <= rsp_ok_next;
        rsp_old_reg   <= rsp_old_next;
        rsp_live_reg  <= rsp_live_next;
        rsp_empty_reg <= rsp_empty_next;
        rsp_room_reg  <= rsp_room_next;
    end

endmodule

[test/slab_ms_checker.sv]
// ============================================================================
// slab_ms_checker
// Watches the request, response and configuration ports of the slab
// allocator. Keeps its own copy of the arena (marks, free list, bump pointer,
// live count), works out the response owed for every accepted request and
// compares each delivered response with the oldest one owed.
// ============================================================================
module slab_ms_checker
    import slab_ms_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [CNT_W-1:0]    cfg_wr_data,
    slab_ms_req_if              req,
    slab_ms_rsp_if              rsp,
    output int                  mismatches,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot_out;
        logic               ok;
        logic [MARK_W-1:0]  old_mark;
        logic [CNT_W-1:0]   live_count;
        logic               arena_empty;
        logic               has_room;
    } arena_rsp_t;

    // Shadow arena
    logic [MARK_W-1:0]  mark_mem [SLOTS];
    logic [SLOT_W-1:0]  link_mem [SLOTS];
    logic [CNT_W-1:0]   slot_cfg;
    logic [SLOT_W-1:0]  head;
    logic               list_empty;
    logic [CNT_W-1:0]   bump;
    logic [CNT_W-1:0]   live;

    arena_rsp_t         owed_rsp_q [$];

    // Apply one request to the shadow arena and return the response it owes
    function automatic arena_rsp_t advance_arena(input logic [MODE_W-1:0] mode,
                                                 input logic [SLOT_W-1:0] slot,
                                                 input logic [MARK_W-1:0] mval);
        int unsigned usable;
        int unsigned walk;
        int unsigned idx;
        arena_rsp_t  res;
        res    = '0;
        usable = (slot_cfg < SLOTS) ? slot_cfg : SLOTS;
        case (mode)
            MODE_ALLOC:
            begin
                if (!list_empty)
                begin
                    // Pop the free list; a self link marks its tail
                    res.slot_out = head;
                    res.ok       = 1'b1;
                    if (link_mem[head] == head)
                        list_empty = 1'b1;
                    else
                        head = link_mem[head];
                    live = (live == '1) ? live : live + 1'b1;
                end
                else if (bump < usable)
                begin
                    res.slot_out = bump[SLOT_W-1:0];
                    res.ok       = 1'b1;
                    bump         = bump + 1'b1;
                    live = (live == '1) ? live : live + 1'b1;
                end
            end
            MODE_MARK:
            begin
                if (slot < usable)
                begin
                    res.old_mark   = mark_mem[slot];
                    mark_mem[slot] = (mval == MARK_SPARE) ? MARK_BLACK : mval;
                    res.ok         = 1'b1;
                end
            end
            MODE_SWEEP:
            begin
                // Rebuild the free list from white slots, whiten the rest
                walk       = (bump < usable) ? bump : usable;
                list_empty = 1'b1;
                head       = '0;
                live       = '0;
                for (idx = 0; idx < walk; idx++)
                begin
                    if (mark_mem[idx] == MARK_WHITE)
                    begin
                        link_mem[idx] = list_empty ? SLOT_W'(idx) : head;
                        head          = SLOT_W'(idx);
                        list_empty    = 1'b0;
                    end
                    else
                    begin
                        mark_mem[idx] = MARK_WHITE;
                        live = (live == '1) ? live : live + 1'b1;
                    end
                end
                res.arena_empty = (live == '0);
                res.has_room    = (int'(live) * ROOM_DEN < int'(usable) * ROOM_NUM);
            end
            default:
            begin
            end
        endcase
        res.live_count = live;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("[%0t] response mismatch on %s: expected 0x%0h, got 0x%0h",
                 $realtime, what, want, got);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
            report_mismatch(what, want, got);
    endtask

    // Track config, predict on request, compare on response
    always @(posedge clk or negedge rst_n)
    begin
        arena_rsp_t want;
        int unsigned idx;
        if (!rst_n)
        begin
            for (idx = 0; idx < SLOTS; idx++)
            begin
                mark_mem[idx] = MARK_WHITE;
                link_mem[idx] = '0;
            end
            slot_cfg   = CNT_W'(SLOTS);
            head       = '0;
            list_empty = 1'b1;
            bump       = '0;
            live       = '0;
            owed_rsp_q.delete();
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_wr_en)
                slot_cfg = cfg_wr_data;
            if (req.valid && req.ready)
                owed_rsp_q.push_back(advance_arena(req.mode, req.slot, req.mark_value));
            if (rsp.valid && rsp.ready)
            begin
                if (owed_rsp_q.size() == 0)
                    report_mismatch("unrequested response", 32'd0, 32'd1);
                else
                begin
                    want = owed_rsp_q.pop_front();
                    check_field("slot_out", want.slot_out, rsp.slot_out);
                    check_field("ok", want.ok, rsp.ok);
                    check_field("old_mark", want.old_mark, rsp.old_mark);
                    check_field("live_count", want.live_count, rsp.live_count);
                    check_field("arena_empty", want.arena_empty, rsp.arena_empty);
                    check_field("has_room", want.has_room, rsp.has_room);
                end
            end
            pending = owed_rsp_q.size();
        end
    end

endmodule

[test/tb.sv]
// ============================================================================
// tb
// Drives the slab allocator: a directed pass over allocation from the bump
// pointer and the free list, marking, sweeps and shrunk or empty arenas, then
// random phases under many slot counts with full-arena sweeps near the fill
// threshold. Both channels idle and stall at random; the checker judges.
// ============================================================================
module tb;
    import slab_ms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
    localparam int ITEM_TARGET = 950;
    localparam int QUIET_AFTER = 860;
    localparam int CYCLE_LIMIT = 1000000;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [CNT_W-1:0]   cfg_wr_data;
    int                 mismatches;
    int                 pending;

    int                 gap_pct;
    int                 stall_pct;
    int                 items_sent;
    int unsigned        usable_now;
    int                 cycle_count;

    slab_ms_req_if req_ch ();
    slab_ms_rsp_if rsp_ch ();

    slab_allocator_mark_sweep_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    slab_ms_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Reset
    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
    end

    // Run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // Response side: stall in random bursts
    initial
    begin
        int hold;
        hold         = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold--;
            end
            else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                rsp_ch.ready <= 1'b0;
                hold = $urandom_range(0, 5);
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Present one item, optionally after an idle burst; return at a falling edge
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [SLOT_W-1:0] slot,
                             input logic [MARK_W-1:0] mval);
        if (items_sent >= QUIET_AFTER)
        begin
            gap_pct   = 0;
            stall_pct = 0;
        end
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.mode       <= mode;
        req_ch.slot       <= slot;
        req_ch.mark_value <= mval;
        do
            @(posedge clk);
        while (!req_ch.ready);
        items_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every owed response has come back
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_slot_count(input logic [CNT_W-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        usable_now  = (value > SLOTS) ? SLOTS : value;
        @(negedge clk);
    endtask

    // Mostly marks on the low, allocated region; some anywhere in the slot range
    task automatic random_item();
        int unsigned pick;
        int unsigned span;
        logic [SLOT_W-1:0] target;
        pick = $urandom_range(0, 99);
        span = (usable_now > 128) ? 128 : usable_now;
        if ($urandom_range(0, 3) == 0)
            target = SLOT_W'($urandom);
        else
            target = SLOT_W'($urandom_range(0, span));
        if (pick < 38)
            send_item(MODE_ALLOC, SLOT_W'($urandom), MARK_W'($urandom));
        else if (pick < 84)
            send_item(MODE_MARK, target, MARK_W'($urandom));
        else if (pick < 94)
            send_item(MODE_SWEEP, SLOT_W'($urandom), MARK_W'($urandom));
        else
            send_item(MODE_NOP, SLOT_W'($urandom), MARK_W'($urandom));
    endtask

    // Allocate the whole arena, keep all but up to two slots live, sweep, reuse
    task automatic fill_and_sweep();
        int unsigned whites;
        int unsigned offset;
        int unsigned idx;
        logic [MARK_W-1:0] keep;
        whites = $urandom_range(0, 2);
        offset = $urandom_range(0, usable_now - 1);
        repeat (usable_now) send_item(MODE_ALLOC, SLOT_W'($urandom), MARK_W'($urandom));
        for (idx = 0; idx < usable_now; idx++)
        begin
            case ($urandom_range(0, 2))
                0: keep = MARK_GREY;
                1: keep = MARK_BLACK;
                default: keep = MARK_SPARE;
            endcase
            if ((idx + offset) % usable_now < whites)
                keep = MARK_WHITE;
            send_item(MODE_MARK, SLOT_W'(idx), keep);
        end
        send_item(MODE_SWEEP, SLOT_W'($urandom), MARK_W'($urandom));
        repeat (whites + 1) send_item(MODE_ALLOC, SLOT_W'($urandom), MARK_W'($urandom));
    endtask

    // Stimulus and verdict
    initial
    begin
        int phase;
        int unsigned pick;
        logic [CNT_W-1:0] new_count;

        req_ch.valid      = 1'b0;
        req_ch.mode       = MODE_ALLOC;
        req_ch.slot       = '0;
        req_ch.mark_value = MARK_WHITE;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        gap_pct           = 0;
        stall_pct         = 0;
        items_sent        = 0;
        usable_now        = SLOTS;

        wait (rst_n === 1'b1);
        @(negedge clk);

        // Empty arena, no-op, spare mark stored as black, top slot
        send_item(MODE_SWEEP, '0, MARK_WHITE);
        send_item(MODE_NOP, '1, MARK_SPARE);
        send_item(MODE_MARK, '0, MARK_SPARE);
        send_item(MODE_MARK, '1, MARK_BLACK);
        send_item(MODE_MARK, '0, MARK_GREY);

        // Bump allocation, then a sweep that frees one white slot
        repeat (4) send_item(MODE_ALLOC, '0, MARK_WHITE);
        send_item(MODE_MARK, SLOT_W'(1), MARK_BLACK);
        send_item(MODE_MARK, SLOT_W'(2), MARK_GREY);
        send_item(MODE_SWEEP, '0, MARK_WHITE);
        send_item(MODE_ALLOC, '0, MARK_WHITE);
        send_item(MODE_ALLOC, '0, MARK_WHITE);

        // Shrink below the bump pointer: out-of-range mark, failed alloc,
        // partial sweep and a two-entry free list drained past its end
        write_slot_count(CNT_W'(2));
        send_item(MODE_MARK, SLOT_W'(2), MARK_BLACK);
        send_item(MODE_ALLOC, '0, MARK_WHITE);
        send_item(MODE_SWEEP, '0, MARK_WHITE);
        repeat (3) send_item(MODE_ALLOC, '0, MARK_WHITE);

        // No usable slots at all
        write_slot_count(CNT_W'(0));
        send_item(MODE_ALLOC, '0, MARK_WHITE);
        send_item(MODE_MARK, '0, MARK_BLACK);
        send_item(MODE_SWEEP, '0, MARK_WHITE);

        // Oversized count clamps to the arena; the top slot kept its mark
        write_slot_count('1);
        send_item(MODE_MARK, '1, MARK_WHITE);

        // Random phases under varied slot counts and idling
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (phase == 0)
                new_count = CNT_W'(1);
            else if (pick < 45)
                new_count = CNT_W'($urandom_range(1, 64));
            else if (pick < 60)
                new_count = CNT_W'($urandom_range(65, 2000));
            else if (pick < 70)
                new_count = CNT_W'(SLOTS);
            else if (pick < 78)
                new_count = CNT_W'($urandom_range(SLOTS + 1, 65535));
            else if (pick < 85)
                new_count = '0;
            else
                new_count = CNT_W'($urandom_range(1, 65535));
            write_slot_count(new_count);
            gap_pct   = $urandom_range(0, 2) * 15;
            stall_pct = $urandom_range(0, 2) * 15;
            if (usable_now > 0 && usable_now <= 50 && $urandom_range(0, 2) == 0)
                fill_and_sweep();
            else
                repeat ($urandom_range(30, 80)) random_item();
            phase++;
        end

        wait_idle();
        repeat (8) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
